### rtl/core/set_assoc_lru_cache_tags_defines.svh
// assertion macros shared by the checker
`ifndef SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH
`define SET_ASSOC_LRU_CACHE_TAGS_DEFINES_SVH

// same-cycle implication, quiet during reset
`define SLA_ASSERT_NOW(label, pre, post) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (pre) |-> (post)) \
        else $error("sla checker: property failed");

// next-cycle implication, checked also while reset is applied
`define SLA_ASSERT_NEXT(label, pre, post) \
    label: assert property (@(posedge i_clk) (pre) |=> (post)) \
        else $error("sla checker: property failed");

`endif

### rtl/core/sla_pkg.sv
// shared types and codes of the lru tag store
`timescale 1ns / 1ps
package sla_pkg;

    localparam logic [1:0] OP_FETCH  = 2'd0;
    localparam logic [1:0] OP_LOAD   = 2'd1;
    localparam logic [1:0] OP_STORE  = 2'd2;
    localparam logic [1:0] OP_MODIFY = 2'd3;

    localparam logic [1:0] OUT_HIT   = 2'd0;
    localparam logic [1:0] OUT_FILL  = 2'd1;
    localparam logic [1:0] OUT_EVICT = 2'd2;

    localparam logic [1:0] CFG_SET_BITS    = 2'd0;
    localparam logic [1:0] CFG_OFFSET_BITS = 2'd1;
    localparam logic [1:0] CFG_WAYS        = 2'd2;

    typedef struct packed {
        logic [2:0] set_index_bits;
        logic [5:0] offset_bits;
        logic [3:0] ways_in_use;
    } t_cfg;

    typedef struct packed {
        logic [1:0]  outcome;
        logic        last_of_run;
        logic [31:0] hit_total;
        logic [31:0] miss_total;
        logic [31:0] eviction_total;
    } t_result;

endpackage

### rtl/core/sla_fifo.sv
// small register queue between pipeline parts
`timescale 1ns / 1ps
module sla_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic [WIDTH-1:0] o_data,
    output logic             o_full,
    output logic             o_empty
);
    localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PW-1:0]    r_wr_ptr, r_rd_ptr;
    logic [CW-1:0]    r_count;
    logic             do_push, do_pop;

    assign o_full  = (r_count == CW'(DEPTH));
    assign o_empty = (r_count == '0);
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;
    assign o_data  = r_mem[r_rd_ptr];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= (r_wr_ptr == PW'(DEPTH - 1)) ? '0 : r_wr_ptr + 1'b1;
            end
            if (do_pop) begin
                r_rd_ptr <= (r_rd_ptr == PW'(DEPTH - 1)) ? '0 : r_rd_ptr + 1'b1;
            end
            r_count <= r_count + CW'(do_push) - CW'(do_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end
endmodule

### rtl/core/sla_front.sv
// access decode: drops fetches, splits the address into set and tag
`timescale 1ns / 1ps
module sla_front #(
    parameter int MAX_SETS  = 64,
    parameter int ADDR_BITS = 64,
    parameter int SET_W     = 6,
    parameter int TAG_W     = 64
) (
    input  sla_pkg::t_cfg            i_cfg,
    input  logic                     i_push,
    input  logic [1:0]               i_operation,
    input  logic [63:0]              i_address,
    input  logic                     i_busy,
    input  logic                     i_q_full,
    output logic                     o_full,
    output logic                     o_q_push,
    output logic [TAG_W+SET_W:0]     o_q_item
);
    localparam int          MAX_SET_BITS = $clog2(MAX_SETS + 1) - 1;
    localparam logic [63:0] ADDR_MASK    =
        (ADDR_BITS >= 64) ? '1 : ((64'd1 << ADDR_BITS) - 64'd1);

    logic [63:0]      addr_m, addr_off, set_raw, tag_raw;
    logic [3:0]       s_eff;
    logic [6:0]       tag_sh;
    logic [SET_W-1:0] set_idx;

    always_comb begin
        addr_m   = i_address & ADDR_MASK;
        s_eff    = (int'(i_cfg.set_index_bits) > MAX_SET_BITS) ?
                   4'(MAX_SET_BITS) : {1'b0, i_cfg.set_index_bits};
        addr_off = addr_m >> i_cfg.offset_bits;
        set_raw  = addr_off & ((64'd1 << s_eff) - 64'd1) & 64'(MAX_SETS - 1);
        set_idx  = set_raw[SET_W-1:0];
        tag_sh   = {1'b0, i_cfg.offset_bits} + {3'b000, s_eff};
        tag_raw  = tag_sh[6] ? 64'd0 : (addr_m >> tag_sh[5:0]);
    end

    assign o_full   = i_q_full || i_busy;
    assign o_q_push = i_push && !o_full && (i_operation != sla_pkg::OP_FETCH);
    assign o_q_item = {(i_operation == sla_pkg::OP_MODIFY), set_idx, tag_raw[TAG_W-1:0]};
endmodule

### rtl/core/sla_back.sv
// set lookup, lru update and running counts over the tag ram
`timescale 1ns / 1ps
module sla_back #(
    parameter int MAX_SETS = 64,
    parameter int MAX_WAYS = 8,
    parameter int SET_W    = 6,
    parameter int TAG_W    = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic [3:0]           i_ways,
    input  logic                 i_q_empty,
    input  logic [TAG_W+SET_W:0] i_q_item,
    output logic                 o_q_pop,
    input  logic                 i_out_full,
    output logic                 o_out_push,
    output sla_pkg::t_result     o_out_data,
    output logic                 o_busy
);
    localparam int RW     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
    localparam int EW     = $clog2(MAX_WAYS + 1);
    localparam int ITEM_W = TAG_W + SET_W + 1;

    typedef enum logic [1:0] {S_CLEAR, S_IDLE, S_CALC, S_AGAIN} t_state;

    logic [MAX_WAYS-1:0][TAG_W-1:0] mem_tag   [MAX_SETS];
    logic [MAX_WAYS-1:0]            mem_valid [MAX_SETS];
    logic [MAX_WAYS-1:0][RW-1:0]    mem_rank  [MAX_SETS];

    t_state                         r_state;
    logic [SET_W-1:0]               r_clr;
    logic [ITEM_W-1:0]              r_item;
    logic                           r_second;
    logic [31:0]                    r_hits, r_misses, r_evicts;
    logic [MAX_WAYS-1:0][TAG_W-1:0] r_rd_tag;
    logic [MAX_WAYS-1:0]            r_rd_valid;
    logic [MAX_WAYS-1:0][RW-1:0]    r_rd_rank;

    logic                           rd_en, wr_en;
    logic [SET_W-1:0]               rd_set, wr_set;
    logic [MAX_WAYS-1:0][TAG_W-1:0] wr_tag;
    logic [MAX_WAYS-1:0]            wr_valid;
    logic [MAX_WAYS-1:0][RW-1:0]    wr_rank, new_rank, init_rank;
    logic [MAX_WAYS-1:0][TAG_W-1:0] new_tag;
    logic [MAX_WAYS-1:0]            new_valid;
    logic [MAX_WAYS-1:0]            in_use, match, free, hit_sel, free_sel, evict_sel, sel;
    logic [EW-1:0]                  e_eff;
    logic [RW-1:0]                  pick_rk, last_rk;
    logic                           hit, any_free;
    logic [1:0]                     outcome;
    logic [31:0]                    n_hits, n_misses, n_evicts;
    logic [TAG_W-1:0]               it_tag;
    logic [SET_W-1:0]               it_set;
    logic                           it_twice;

    assign it_tag   = r_item[TAG_W-1:0];
    assign it_set   = r_item[TAG_W +: SET_W];
    assign it_twice = r_item[ITEM_W-1];

    // issue a row read when a result slot is free
    always_comb begin
        rd_en   = 1'b0;
        o_q_pop = 1'b0;
        rd_set  = it_set;
        case (r_state)
            S_IDLE: begin
                rd_set  = i_q_item[TAG_W +: SET_W];
                rd_en   = !i_q_empty && !i_out_full;
                o_q_pop = rd_en;
            end
            S_AGAIN: rd_en = !i_out_full;
            default: rd_en = 1'b0;
        endcase
    end

    always_comb begin
        e_eff = (i_ways == 4'd0) ? EW'(1) :
                (int'(i_ways) > MAX_WAYS) ? EW'(MAX_WAYS) : EW'(i_ways);
        last_rk = RW'(e_eff - 1'b1);
        for (int w = 0; w < MAX_WAYS; w++) begin
            init_rank[w] = RW'(w);
            in_use[w]    = {1'b0, r_rd_rank[w]} < (RW + 1)'(e_eff);
            match[w]     = in_use[w] && r_rd_valid[w] && (r_rd_tag[w] == it_tag);
            free[w]      = in_use[w] && !r_rd_valid[w];
            evict_sel[w] = (r_rd_rank[w] == last_rk);
        end
        // lowest rank wins among candidates; ranks form a permutation
        for (int w = 0; w < MAX_WAYS; w++) begin
            hit_sel[w]  = match[w];
            free_sel[w] = free[w];
            for (int u = 0; u < MAX_WAYS; u++) begin
                if (u != w && match[u] && r_rd_rank[u] < r_rd_rank[w]) begin
                    hit_sel[w] = 1'b0;
                end
                if (u != w && free[u] && r_rd_rank[u] < r_rd_rank[w]) begin
                    free_sel[w] = 1'b0;
                end
            end
        end
        hit      = |match;
        any_free = |free;
        sel      = hit ? hit_sel : (any_free ? free_sel : evict_sel);
        outcome  = hit ? sla_pkg::OUT_HIT :
                   (any_free ? sla_pkg::OUT_FILL : sla_pkg::OUT_EVICT);
        pick_rk  = '0;
        for (int w = 0; w < MAX_WAYS; w++) begin
            if (sel[w]) begin
                pick_rk = pick_rk | r_rd_rank[w];
            end
        end
        for (int w = 0; w < MAX_WAYS; w++) begin
            new_tag[w]   = (!hit && sel[w]) ? it_tag : r_rd_tag[w];
            new_valid[w] = r_rd_valid[w] || (!hit && sel[w]);
            if (r_rd_rank[w] < pick_rk) begin
                new_rank[w] = r_rd_rank[w] + 1'b1;
            end else if (r_rd_rank[w] == pick_rk) begin
                new_rank[w] = '0;
            end else begin
                new_rank[w] = r_rd_rank[w];
            end
        end
        n_hits   = r_hits + 32'(hit);
        n_misses = r_misses + 32'(!hit);
        n_evicts = r_evicts + 32'(outcome == sla_pkg::OUT_EVICT);
    end

    always_comb begin
        wr_en    = (r_state == S_CLEAR) || (r_state == S_CALC);
        wr_set   = (r_state == S_CLEAR) ? r_clr : it_set;
        wr_tag   = (r_state == S_CLEAR) ? '0 : new_tag;
        wr_valid = (r_state == S_CLEAR) ? '0 : new_valid;
        wr_rank  = (r_state == S_CLEAR) ? init_rank : new_rank;
    end

    assign o_busy                    = (r_state == S_CLEAR);
    assign o_out_push                = (r_state == S_CALC);
    assign o_out_data.outcome        = outcome;
    assign o_out_data.last_of_run    = !it_twice || r_second;
    assign o_out_data.hit_total      = n_hits;
    assign o_out_data.miss_total     = n_misses;
    assign o_out_data.eviction_total = n_evicts;

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            mem_tag[wr_set]   <= wr_tag;
            mem_valid[wr_set] <= wr_valid;
            mem_rank[wr_set]  <= wr_rank;
        end
        if (rd_en) begin
            r_rd_tag   <= mem_tag[rd_set];
            r_rd_valid <= mem_valid[rd_set];
            r_rd_rank  <= mem_rank[rd_set];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_second <= 1'b0;
            r_hits   <= '0;
            r_misses <= '0;
            r_evicts <= '0;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == SET_W'(MAX_SETS - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (rd_en) begin
                        r_item   <= i_q_item;
                        r_second <= 1'b0;
                        r_state  <= S_CALC;
                    end
                end
                S_CALC: begin
                    r_hits   <= n_hits;
                    r_misses <= n_misses;
                    r_evicts <= n_evicts;
                    if (it_twice && !r_second) begin
                        r_second <= 1'b1;
                        r_state  <= S_AGAIN;
                    end else begin
                        r_state <= S_IDLE;
                    end
                end
                S_AGAIN: begin
                    if (rd_en) begin
                        r_state <= S_CALC;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

### rtl/core/set_assoc_lru_cache_tags.sv
// top level of the set-associative tag store with true lru replacement
// in the back end a load or store reads its set row, then updates it; a modify does both twice
// fetches are dropped by the front end in the cycle they are taken
// a result word reaches the outputs through the access queue, the set row read and the result queue
// after reset a clearing pass over all MAX_SETS set rows holds full high
`timescale 1ns / 1ps
module set_assoc_lru_cache_tags #(
    parameter int MAX_SETS  = 64,
    parameter int MAX_WAYS  = 8,
    parameter int ADDR_BITS = 64
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // access words in
    input  logic        push,
    output logic        full,
    input  logic [1:0]  i_operation,
    input  logic [63:0] i_address,
    // result words out
    output logic        empty,
    input  logic        pop,
    output logic [1:0]  o_outcome,
    output logic        o_last_of_run,
    output logic [31:0] o_hit_total,
    output logic [31:0] o_miss_total,
    output logic [31:0] o_eviction_total,
    // register writes
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [1:0]  i_cfg_index,
    input  logic [5:0]  i_cfg_data
);
    localparam int SET_W  = $clog2(MAX_SETS);
    localparam int TAG_W  = ADDR_BITS;
    localparam int ITEM_W = TAG_W + SET_W + 1;
    localparam int RES_W  = $bits(sla_pkg::t_result);

    sla_pkg::t_cfg     r_cfg;
    logic              q_push, q_full, q_empty, q_pop, busy;
    logic [ITEM_W-1:0] q_in, q_out;
    logic              out_push, out_full;
    sla_pkg::t_result  out_in, out_head;

    // registers are always writable; the sender must change them only while the block is idle (not enforced here)
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.set_index_bits <= 3'd1;
            r_cfg.offset_bits    <= 6'd1;
            r_cfg.ways_in_use    <= 4'd8;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                sla_pkg::CFG_SET_BITS:    r_cfg.set_index_bits <= i_cfg_data[2:0];
                sla_pkg::CFG_OFFSET_BITS: r_cfg.offset_bits    <= i_cfg_data;
                sla_pkg::CFG_WAYS:        r_cfg.ways_in_use    <= i_cfg_data[3:0];
                default:                  r_cfg                <= r_cfg;
            endcase
        end
    end

    // front end: decode and filter accesses
    sla_front #(
        .MAX_SETS  (MAX_SETS),
        .ADDR_BITS (ADDR_BITS),
        .SET_W     (SET_W),
        .TAG_W     (TAG_W)
    ) u_front (
        .i_cfg       (r_cfg),
        .i_push      (push),
        .i_operation (i_operation),
        .i_address   (i_address),
        .i_busy      (busy),
        .i_q_full    (q_full),
        .o_full      (full),
        .o_q_push    (q_push),
        .o_q_item    (q_in)
    );

    // decoupling queue between decode and the tag ram
    sla_fifo #(
        .WIDTH (ITEM_W),
        .DEPTH (2)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    // back end: read set row, pick way, write row back, bump counters
    sla_back #(
        .MAX_SETS (MAX_SETS),
        .MAX_WAYS (MAX_WAYS),
        .SET_W    (SET_W),
        .TAG_W    (TAG_W)
    ) u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ways     (r_cfg.ways_in_use),
        .i_q_empty  (q_empty),
        .i_q_item   (q_out),
        .o_q_pop    (q_pop),
        .i_out_full (out_full),
        .o_out_push (out_push),
        .o_out_data (out_in),
        .o_busy     (busy)
    );

    // result queue decouples the consumer from the tag ram
    sla_fifo #(
        .WIDTH (RES_W),
        .DEPTH (4)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_in),
        .i_pop   (pop),
        .o_data  (out_head),
        .o_full  (out_full),
        .o_empty (empty)
    );

    assign o_outcome        = out_head.outcome;
    assign o_last_of_run    = out_head.last_of_run;
    assign o_hit_total      = out_head.hit_total;
    assign o_miss_total     = out_head.miss_total;
    assign o_eviction_total = out_head.eviction_total;
endmodule

### rtl/core/sla_checker.sv
// port-level checks of the lru tag store, bound to the top level
`timescale 1ns / 1ps
`include "set_assoc_lru_cache_tags_defines.svh"
module sla_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        push,
    input logic        full,
    input logic        empty,
    input logic        pop,
    input logic [1:0]  o_outcome,
    input logic        o_last_of_run,
    input logic [31:0] o_hit_total,
    input logic [31:0] o_miss_total,
    input logic [31:0] o_eviction_total
);
    // clearing pass holds off accesses right after reset
    `SLA_ASSERT_NEXT(a_full_after_reset, !i_rst_n, full)
    // no result words survive reset
    `SLA_ASSERT_NEXT(a_empty_after_reset, !i_rst_n, empty)
    // a waiting word holds until taken
    `SLA_ASSERT_NOW(a_head_holds, ($past(!empty && !pop) && $past(i_rst_n)), (!empty && $stable(o_hit_total) && $stable(o_miss_total) && $stable(o_outcome) && $stable(o_last_of_run) && $stable(o_eviction_total)))
    // nothing is taken while full is shown
    `SLA_ASSERT_NOW(a_no_push_when_full, (full && i_rst_n), (full || !push))
endmodule

bind set_assoc_lru_cache_tags sla_checker u_sla_checker (.*);
